// File: src/lfsc_pkg.sv
// Shared types, constants and defaults for the logistic fan speed curve block.
`timescale 1ns / 1ps
package lfsc_pkg;

    localparam int MAX_FANS_DEF  = 8;
    localparam int FRAC_BITS_DEF = 12;

    // Degrees from millidegrees: floor(|t| * DEG_RECIP / 2^DEG_SHIFT) == floor(|t| / 1000).
    localparam logic [17:0] DEG_RECIP = 18'd134218;
    localparam int          DEG_SHIFT = 27;

    localparam logic signed [17:0] ARG_LIMIT = 18'sd65536;
    localparam logic signed [17:0] LOG2E_Q16 = 18'sd94548;
    localparam logic [15:0]        POLY_C1   = 16'd43047;
    localparam logic [14:0]        POLY_C2   = 15'd22489;

    localparam logic [2:0] REG_FAN_COUNT = 3'd0;
    localparam logic [2:0] REG_MIN_SPEED = 3'd1;
    localparam logic [2:0] REG_MAX_SPEED = 3'd2;
    localparam logic [2:0] REG_GAIN      = 3'd3;
    localparam logic [2:0] REG_MIDPOINT  = 3'd4;

    typedef struct packed {
        logic [3:0]         fan_count;
        logic [15:0]        min_speed;
        logic [15:0]        max_speed;
        logic signed [15:0] curve_gain;
        logic signed [7:0]  midpoint_deg;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        fan_count:    4'd1,
        min_speed:    16'd2300,
        max_speed:    16'd5500,
        curve_gain:   16'sd410,
        midpoint_deg: 8'sd55
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_div_state;

endpackage

// File: src/lfsc_front.sv
// Front pipeline: degrees conversion, logistic argument and fixed-point exponential.
`timescale 1ns / 1ps
module lfsc_front #(
    parameter int FRAC_BITS = lfsc_pkg::FRAC_BITS_DEF,
    parameter int DW        = FRAC_BITS + 25
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lfsc_pkg::t_cfg      i_cfg,
    input  logic                i_push,
    input  logic signed [17:0]  i_temp,
    output logic                o_full,
    output logic                o_q_push,
    output logic [DW-1:0]       o_q_den,
    input  logic                i_q_full
);

    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, accept;

    logic signed [9:0]        r_x;
    logic signed [28:0]       r_a;
    logic signed [35:0]       r_p;
    logic signed [7:0]        r_n3, r_n4;
    logic [FRAC_BITS-1:0]     r_f3;
    logic [15:0]              r_t1;
    logic [16:0]              r_m;

    logic [17:0]              t_abs;
    logic [35:0]              x_prod;
    logic [8:0]               x_mag;
    logic signed [10:0]       d;
    logic signed [28:0]       a_c;
    logic signed [17:0]       a_sat;
    logic [30:0]              t1_prod;
    logic [32:0]              t2_prod;
    logic signed [8:0]        s;
    logic [DW-1:0]            m_ext, e_val;

    assign rdy5   = !r_v5 || !i_q_full;
    assign rdy4   = !r_v4 || rdy5;
    assign rdy3   = !r_v3 || rdy4;
    assign rdy2   = !r_v2 || rdy3;
    assign rdy1   = !r_v1 || rdy2;
    assign accept = i_push && rdy1;
    assign o_full = !rdy1;

    // The denominator 1 + e^a is formed from the last stage as it enters the queue.
    assign o_q_push = r_v5 && !i_q_full;
    assign o_q_den  = (DW'(1) << FRAC_BITS) + e_val;

    always_comb begin
        t_abs   = i_temp[17] ? 18'(-i_temp) : 18'(i_temp);
        x_prod  = 36'(t_abs) * 36'(lfsc_pkg::DEG_RECIP);
        x_mag   = x_prod[35:27];
        d       = 11'(r_x) - 11'(i_cfg.midpoint_deg);
        a_c     = -(29'(i_cfg.curve_gain) * 29'(d));
        if (r_a > 29'(lfsc_pkg::ARG_LIMIT)) begin
            a_sat = lfsc_pkg::ARG_LIMIT;
        end else if (r_a < -29'(lfsc_pkg::ARG_LIMIT)) begin
            a_sat = -lfsc_pkg::ARG_LIMIT;
        end else begin
            a_sat = r_a[17:0];
        end
        t1_prod = 31'(lfsc_pkg::POLY_C2) * 31'(r_p[27:28-FRAC_BITS]);
        t2_prod = (33'(r_t1) + 33'(lfsc_pkg::POLY_C1)) * 33'(r_f3);
        s       = 9'(r_n4) + 9'(FRAC_BITS) - 9'sd16;
        m_ext   = DW'(r_m);
        if (s >= 0) begin
            e_val = m_ext << s[5:0];
        end else begin
            e_val = m_ext >> 6'(-s);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= accept;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
            if (rdy5) r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x <= i_temp[17] ? -10'(x_mag) : 10'(x_mag);
        end
        if (rdy2 && r_v1) begin
            r_a <= a_c;
        end
        if (rdy3 && r_v2) begin
            r_p <= 36'(a_sat) * 36'(lfsc_pkg::LOG2E_Q16);
        end
        if (rdy4 && r_v3) begin
            r_n3 <= r_p[35:28];
            r_f3 <= r_p[27:28-FRAC_BITS];
            r_t1 <= 16'(t1_prod >> FRAC_BITS);
        end
        if (rdy5 && r_v4) begin
            r_n4 <= r_n3;
            r_m  <= 17'h10000 + 17'(t2_prod >> FRAC_BITS);
        end
    end

endmodule

// File: src/lfsc_queue.sv
// Two-entry queue that decouples the curve pipeline from the divider and fan writer.
`timescale 1ns / 1ps
module lfsc_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

endmodule

// File: src/lfsc_back.sv
// Back end: radix-4 divider for the curve quotient and the per-fan write register.
`timescale 1ns / 1ps
module lfsc_back #(
    parameter int MAX_FANS  = lfsc_pkg::MAX_FANS_DEF,
    parameter int FRAC_BITS = lfsc_pkg::FRAC_BITS_DEF,
    parameter int DW        = FRAC_BITS + 25
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lfsc_pkg::t_cfg i_cfg,
    input  logic           i_q_valid,
    input  logic [DW-1:0]  i_q_den,
    output logic           o_q_pop,
    output logic           o_empty,
    input  logic           i_pop,
    output logic [3:0]     o_fan_index,
    output logic [15:0]    o_fan_speed,
    output logic           o_last
);

    localparam int NW = 16 + FRAC_BITS;

    lfsc_pkg::t_div_state r_state, n_state;

    logic [DW-1:0] r_den, r_rem;
    logic [15:0]   r_lo, r_q;
    logic [2:0]    r_step;
    logic          r_ov;
    logic [3:0]    r_idx;
    logic [15:0]   r_speed;

    logic          neg, load_ok, do_load;
    logic [15:0]   mag;
    logic [NW-1:0] num;
    logic [4:0]    cnt5;
    logic [3:0]    cnt;
    logic [DW:0]   rem_a, rem_b, den_x;
    logic [DW-1:0] rem_a2, rem_b2;
    logic          ge_a, ge_b;
    logic [16:0]   sp;

    always_comb begin
        neg  = i_cfg.max_speed < i_cfg.min_speed;
        mag  = neg ? (i_cfg.min_speed - i_cfg.max_speed) : (i_cfg.max_speed - i_cfg.min_speed);
        num  = {mag, {FRAC_BITS{1'b0}}};
        cnt5 = ({1'b0, i_cfg.fan_count} > 5'(MAX_FANS)) ? 5'(MAX_FANS) : {1'b0, i_cfg.fan_count};
        cnt  = cnt5[3:0];

        den_x  = {1'b0, r_den};
        rem_a  = {r_rem, r_lo[15]};
        ge_a   = rem_a >= den_x;
        rem_a2 = ge_a ? DW'(rem_a - den_x) : rem_a[DW-1:0];
        rem_b  = {rem_a2, r_lo[14]};
        ge_b   = rem_b >= den_x;
        rem_b2 = ge_b ? DW'(rem_b - den_x) : rem_b[DW-1:0];

        if (neg) begin
            sp = {1'b0, i_cfg.min_speed} - ({1'b0, r_q} + 17'(r_rem != '0));
        end else begin
            sp = {1'b0, i_cfg.min_speed} + {1'b0, r_q};
        end
        load_ok = !r_ov || (i_pop && o_last);
    end

    always_comb begin
        n_state = r_state;
        o_q_pop = 1'b0;
        do_load = 1'b0;
        case (r_state)
            lfsc_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_state = lfsc_pkg::ST_RUN;
                end
            end
            lfsc_pkg::ST_RUN: begin
                if (r_step == 3'd7) n_state = lfsc_pkg::ST_DONE;
            end
            lfsc_pkg::ST_DONE: begin
                if (cnt == 4'd0) begin
                    n_state = lfsc_pkg::ST_IDLE;
                end else if (load_ok) begin
                    do_load = 1'b1;
                    n_state = lfsc_pkg::ST_IDLE;
                end
            end
            default: n_state = lfsc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lfsc_pkg::ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (do_load) begin
                r_ov <= 1'b1;
            end else if (i_pop && r_ov && o_last) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_den  <= i_q_den;
            r_rem  <= DW'(num[NW-1:16]);
            r_lo   <= num[15:0];
            r_q    <= '0;
            r_step <= '0;
        end else if (r_state == lfsc_pkg::ST_RUN) begin
            r_rem  <= rem_b2;
            r_lo   <= {r_lo[13:0], 2'b00};
            r_q    <= {r_q[13:0], ge_a, ge_b};
            r_step <= r_step + 3'd1;
        end
        if (do_load) begin
            r_idx   <= 4'd1;
            r_speed <= sp[15:0];
        end else if (i_pop && r_ov && !o_last) begin
            r_idx <= r_idx + 4'd1;
        end
    end

    assign o_empty     = !r_ov;
    assign o_fan_index = r_idx;
    assign o_fan_speed = r_speed;
    assign o_last      = (r_idx == cnt);

endmodule

// File: src/logistic_fan_speed_curve.sv
// Top level of the logistic fan speed curve block: configuration registers and wiring.
`timescale 1ns / 1ps
// Each pushed temperature sample in millidegrees becomes whole degrees, goes through the
// logistic curve min + (max - min) / (1 + e^(-k(x - mid))) in fixed point, and yields one
// write per fan, numbered from one, all with the same speed and with o_last on the final
// write; a fan count of zero yields no writes, a count above MAX_FANS yields MAX_FANS.
// A sample passes through the curve pipeline, which can take a new sample every cycle
// while full is low, then waits in a two-entry queue for the divider. The divider retires
// two quotient bits a cycle and takes a new sample only when done with the last. The fan
// writes of one sample drain from the output register, one transfer per cycle while pop
// is high, while the next sample is being divided. The user must write registers through
// i_cfg_we, i_cfg_index and i_cfg_data only while the block is idle; the block itself
// does not enforce this. Writes to indexes beyond the register list are ignored.
module logistic_fan_speed_curve #(
    parameter int MAX_FANS  = lfsc_pkg::MAX_FANS_DEF,
    parameter int FRAC_BITS = lfsc_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               push,
    output logic               full,
    input  logic signed [17:0] i_temp_millideg,
    output logic               empty,
    input  logic               pop,
    output logic [3:0]         o_fan_index,
    output logic [15:0]        o_fan_speed,
    output logic               o_last
);

    localparam int DW = FRAC_BITS + 25;

    lfsc_pkg::t_cfg r_cfg;

    logic          q_push, q_full, q_pop, q_valid;
    logic [DW-1:0] q_din, q_dout;

    // Configuration registers; each write takes effect at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= lfsc_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lfsc_pkg::REG_FAN_COUNT: r_cfg.fan_count    <= i_cfg_data[3:0];
                lfsc_pkg::REG_MIN_SPEED: r_cfg.min_speed    <= i_cfg_data;
                lfsc_pkg::REG_MAX_SPEED: r_cfg.max_speed    <= i_cfg_data;
                lfsc_pkg::REG_GAIN:      r_cfg.curve_gain   <= i_cfg_data;
                lfsc_pkg::REG_MIDPOINT:  r_cfg.midpoint_deg <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Curve pipeline: degrees, argument, exponential and denominator.
    lfsc_front #(.FRAC_BITS(FRAC_BITS), .DW(DW)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_push   (push),
        .i_temp   (i_temp_millideg),
        .o_full   (full),
        .o_q_push (q_push),
        .o_q_den  (q_din),
        .i_q_full (q_full)
    );

    lfsc_queue #(.W(DW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_din),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_dout)
    );

    // Divider and fan writer; a write transfers when pop is high and empty is low.
    lfsc_back #(.MAX_FANS(MAX_FANS), .FRAC_BITS(FRAC_BITS), .DW(DW)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_den     (q_dout),
        .o_q_pop     (q_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_fan_index (o_fan_index),
        .o_fan_speed (o_fan_speed),
        .o_last      (o_last)
    );

endmodule

// File: src/lfsc_checker.sv
// Port-level assertions for the logistic fan speed curve block and their bind.
`timescale 1ns / 1ps
module lfsc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [3:0]  o_fan_index,
    input logic [15:0] o_fan_speed,
    input logic        o_last
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result side not empty after reset");

    a_next_fan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_last) |=>
            (!empty && o_fan_index == 4'($past(o_fan_index) + 4'd1)))
        else $error("next fan write did not follow");

    a_same_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_last) |=> (o_fan_speed == $past(o_fan_speed)))
        else $error("fan speed changed within one sample");

    a_index_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_fan_index != 4'd0))
        else $error("fan index zero on a write");

endmodule

bind logistic_fan_speed_curve lfsc_checker u_lfsc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .empty       (empty),
    .pop         (pop),
    .o_fan_index (o_fan_index),
    .o_fan_speed (o_fan_speed),
    .o_last      (o_last)
);

// File: dv/tb_logistic_fan_speed_curve.sv
// Self-checking testbench for the logistic fan speed curve block.
`timescale 1ns / 1ps
module tb_logistic_fan_speed_curve;

    typedef struct {
        logic [3:0]  fan_index;
        logic [15:0] fan_speed;
        logic        last;
    } t_fan_write;

    // The scoreboard keeps its own copy of the registers, predicts the fan writes of
    // every accepted sample and compares each accepted write against the oldest one.
    class fan_write_board;
        lfsc_pkg::t_cfg regs;
        t_fan_write     pending[$];
        int             errors;

        function new();
            regs = lfsc_pkg::CFG_RESET;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] val);
            case (idx)
                lfsc_pkg::REG_FAN_COUNT: regs.fan_count = val[3:0];
                lfsc_pkg::REG_MIN_SPEED: regs.min_speed = val;
                lfsc_pkg::REG_MAX_SPEED: regs.max_speed = val;
                lfsc_pkg::REG_GAIN:      regs.curve_gain = val;
                lfsc_pkg::REG_MIDPOINT:  regs.midpoint_deg = val[7:0];
                default: ;
            endcase
        endfunction

        // e^a for a in Q.12, result in Q.12, with the polynomial approximation of 2^f.
        function longint exp_q12(longint a);
            longint p, u, n, f, t, m, s;
            p = a * 94548;
            u = p + (longint'(24) << 28);
            n = (u >>> 28) - 24;
            f = (u >>> 16) & 4095;
            t = (22489 * f) >>> 12;
            t = ((t + 43047) * f) >>> 12;
            m = 65536 + t;
            s = n + 12 - 16;
            if (s >= 0) return m << s;
            return m >>> (-s);
        endfunction

        function logic [15:0] speed_of(logic signed [17:0] temp);
            longint x, a, den, lo, diff, sp;
            x = longint'(temp) / 1000;
            a = -(longint'(regs.curve_gain) * (x - longint'(regs.midpoint_deg)));
            if (a > 65536) a = 65536;
            if (a < -65536) a = -65536;
            den = 4096 + exp_q12(a);
            lo = regs.min_speed;
            diff = longint'(regs.max_speed) - lo;
            if (diff >= 0) sp = lo + (diff << 12) / den;
            else sp = lo - (((-diff) << 12) + den - 1) / den;
            if (sp < 0) sp = 0;
            if (sp > 65535) sp = 65535;
            return sp[15:0];
        endfunction

        function void note_sample(logic signed [17:0] temp);
            t_fan_write w;
            int cnt;
            logic [15:0] sp;
            sp = speed_of(temp);
            cnt = (regs.fan_count > 8) ? 8 : int'(regs.fan_count);
            for (int i = 0; i < cnt; i++) begin
                w.fan_index = 4'(i + 1);
                w.fan_speed = sp;
                w.last = (i + 1 == cnt);
                pending.push_back(w);
            end
        endfunction

        function void check_write(logic [3:0] idx, logic [15:0] sp, logic lst);
            t_fan_write w;
            if (pending.size() == 0) begin
                $error("unexpected fan write index=%0d speed=%0d", idx, sp);
                errors++;
                return;
            end
            w = pending.pop_front();
            if (idx !== w.fan_index) begin
                $error("fan_index expected %0d actual %0d", w.fan_index, idx);
                errors++;
            end
            if (sp !== w.fan_speed) begin
                $error("fan_speed expected %0d actual %0d", w.fan_speed, sp);
                errors++;
            end
            if (lst !== w.last) begin
                $error("last expected %0d actual %0d", w.last, lst);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_index = '0;
    logic [15:0]        i_cfg_data = '0;
    logic               push = 1'b0;
    logic               full;
    logic signed [17:0] i_temp_millideg = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic [3:0]         o_fan_index;
    logic [15:0]        o_fan_speed;
    logic               o_last;

    fan_write_board board = new();

    // Idle percentages of the two sides; the long hold-off forces the input to stall.
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  recv_hold = 0;
    int  quiet_cycles = 0;
    localparam int WATCHDOG = 20000;

    always #5 i_clk = ~i_clk;

    logistic_fan_speed_curve DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .push(push), .full(full), .i_temp_millideg(i_temp_millideg),
        .empty(empty), .pop(pop),
        .o_fan_index(o_fan_index), .o_fan_speed(o_fan_speed), .o_last(o_last)
    );

    // Result side: check every accepted transfer, then decide pop for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            board.check_write(o_fan_index, o_fan_speed, o_last);
        if (recv_hold > 0) begin
            recv_hold <= recv_hold - 1;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: cycles with no transfer on either side.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Offer one sample, with a random gap first, and hold it until the transfer happens.
    // Push stays high after the transfer so that samples can follow back to back.
    task automatic send_sample(logic signed [17:0] temp);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_temp_millideg <= temp;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        board.note_sample(temp);
    endtask

    // Pause until every predicted write has arrived, plus the pipeline latency.
    task automatic drain();
        push <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        board.write_reg(idx, val);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_all(logic [3:0] cnt, logic [15:0] lo, logic [15:0] hi,
                           logic [15:0] k, logic [7:0] mid);
        write_reg(lfsc_pkg::REG_FAN_COUNT, {12'd0, cnt});
        write_reg(lfsc_pkg::REG_MIN_SPEED, lo);
        write_reg(lfsc_pkg::REG_MAX_SPEED, hi);
        write_reg(lfsc_pkg::REG_GAIN, k);
        write_reg(lfsc_pkg::REG_MIDPOINT, {8'd0, mid});
    endtask

    // Mostly realistic temperatures, sometimes the whole 18-bit range.
    function automatic logic signed [17:0] rand_temp();
        if ($urandom_range(3) == 0) return 18'($urandom);
        return 18'($urandom_range(109998)) - 18'sd9999;
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) send_sample(rand_temp());
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed samples at reset settings: field extremes and the midpoint.
        send_sample(-18'sd9999);
        send_sample(18'sd0);
        send_sample(18'sd54999);
        send_sample(18'sd55000);
        send_sample(18'sd99999);
        send_sample(18'sh1FFFF);
        send_sample(18'sh20000);
        send_sample(-18'sd1);
        drain();
        // No fans at all, then a count above the fan limit.
        write_reg(lfsc_pkg::REG_FAN_COUNT, 16'd0);
        send_sample(18'sd40000);
        send_sample(18'sd70000);
        drain();
        write_reg(lfsc_pkg::REG_FAN_COUNT, 16'd15);
        send_sample(18'sd60000);
        send_sample(18'sd30000);
        drain();
        // Inverted limits give a falling curve; steep gain saturates the argument.
        set_all(4'd8, 16'd65535, 16'd0, 16'h7FFF, 8'h80);
        send_sample(-18'sd9999);
        send_sample(18'sd99999);
        send_sample(18'sh20000);
        drain();
        set_all(4'd3, 16'd0, 16'd65535, 16'h8000, 8'h7F);
        send_sample(18'sd99999);
        send_sample(18'sd127000);
        send_sample(-18'sd128000);
        drain();

        // Random phases with changing settings and idling patterns.
        send_idle_pct = 20; recv_idle_pct = 59;
        set_all(4'($urandom_range(15)), 16'($urandom), 16'($urandom), 16'($urandom),
                8'($urandom));
        random_phase(30);
        // Hold the receiver off so the block fills and stalls the sender.
        recv_hold = 300;
        random_phase(20);
        drain();
        send_idle_pct = 59; recv_idle_pct = 20;
        set_all(4'd1, 16'd2300, 16'd5500, 16'd410, 8'd55);
        random_phase(30);
        drain();
        set_all(4'($urandom_range(15)), 16'($urandom), 16'($urandom), 16'($urandom),
                8'($urandom));
        random_phase(30);
        drain();
        send_idle_pct = 0; recv_idle_pct = 0;
        set_all(4'($urandom_range(8, 1)), 16'($urandom), 16'($urandom),
                16'($urandom_range(2000)), 8'($urandom));
        random_phase(30);
        drain();
        set_all(4'd8, 16'd0, 16'd65535, 16'($urandom), 8'($urandom));
        random_phase(30);
        drain();

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
